@@ design/sector_cache_clock_policy_core_assert.svh @@
// ----------------------------------------------------------------------------
// sector cache clock policy core assertion macros
// shorthand for the concurrent checks of the top level
// ----------------------------------------------------------------------------
`ifndef SECTOR_CACHE_CLOCK_POLICY_CORE_ASSERT_SVH
`define SECTOR_CACHE_CLOCK_POLICY_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define SCCP_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define SCCP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/sccp_pkg.sv @@
// ----------------------------------------------------------------------------
// sccp_pkg
// shared types and constants of the sector cache clock policy core
// ----------------------------------------------------------------------------
package sccp_pkg;

	localparam int NUM_SLOTS_DEF = 64;
	localparam int TAG_W         = 32;
	localparam int SLOT_W        = 6;
	localparam int ENTRY_W       = TAG_W + 2;
	localparam int MAX_OUT       = 64;
	localparam int CNT_W         = 7;
	localparam int QUEUE_DEPTH   = 2;

	typedef enum logic [1:0] {
		MODE_READ  = 2'd0,
		MODE_WRITE = 2'd1,
		MODE_FLUSH = 2'd2,
		MODE_NONE  = 2'd3
	} sccp_mode_e;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LK_RD,
		ST_LK_EV,
		ST_MISS,
		ST_CK_EV,
		ST_FL_RD,
		ST_FL_EV,
		ST_FL_END
	} sccp_state_e;

	typedef struct packed {
		sccp_mode_e        mode;
		logic [TAG_W-1:0]  sector;
	} sccp_item_t;

	typedef struct packed {
		logic clearing;
	} sccp_status_t;

endpackage

@@ design/sccp_ram.sv @@
// ----------------------------------------------------------------------------
// sccp_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module sccp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ design/sccp_front.sv @@
// ----------------------------------------------------------------------------
// sccp_front
// input transfer, mode filter and short queue toward the sequencer
// ----------------------------------------------------------------------------
module sccp_front import sccp_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_stall,
	input  logic [1:0]   mode,
	input  logic [31:0]  sector,
	input  sccp_status_t status,
	output logic         q_valid,
	output sccp_item_t   q_item,
	input  logic         q_pop
);

	localparam int PW = $clog2(QUEUE_DEPTH);

	sccp_item_t      item_q [QUEUE_DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [PW:0]     cnt_q;
	logic            full;
	logic            accept;
	logic            push;
	sccp_mode_e      in_mode;

	assign in_mode  = sccp_mode_e'(mode);
	assign full     = (cnt_q == (PW+1)'(QUEUE_DEPTH));
	assign in_stall = full || status.clearing;
	assign accept   = in_valid && !in_stall;
	// unused mode code is dropped here
	assign push     = accept && (in_mode != MODE_NONE);
	assign q_valid  = (cnt_q != '0);
	assign q_item   = item_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			item_q[wr_ptr_q] <= '{mode: in_mode, sector: sector};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + (PW+1)'(push) - (PW+1)'(q_pop);
		end
	end

endmodule

@@ design/sccp_back.sv @@
// ----------------------------------------------------------------------------
// sccp_back
// slot sequencer: lookup walk, fill, clock sweep, flush walk, result register
// ----------------------------------------------------------------------------
module sccp_back import sccp_pkg::*; #(
	parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         q_valid,
	input  sccp_item_t   q_item,
	output logic         q_pop,
	output sccp_status_t status,
	output logic         out_valid,
	input  logic         out_stall,
	output logic         hit,
	output logic [5:0]   slot,
	output logic         fill_needed,
	output logic         writeback_valid,
	output logic [31:0]  writeback_sector,
	output logic         last
);

	localparam int IW = $clog2(NUM_SLOTS);
	localparam int CW = $clog2(NUM_SLOTS + 1);

	sccp_state_e        state_q, state_d;
	logic [CW-1:0]      idx_q, idx_d;
	logic [CW-1:0]      used_q, used_d;
	logic [IW-1:0]      hand_q, hand_d, hand_nxt;
	logic [CNT_W-1:0]   cnt_q, cnt_d;
	logic               pend_q, pend_d;
	logic [IW-1:0]      pend_slot_q, pend_slot_d;
	logic [TAG_W-1:0]   pend_tag_q, pend_tag_d;
	sccp_mode_e         cur_mode_q, cur_mode_d;
	logic [TAG_W-1:0]   cur_sector_q, cur_sector_d;

	logic               ovalid_q, ovalid_d;
	logic               hit_q, hit_d;
	logic [SLOT_W-1:0]  slot_q, slot_d;
	logic               fill_q, fill_d;
	logic               wbv_q, wbv_d;
	logic [TAG_W-1:0]   wbs_q, wbs_d;
	logic               last_q, last_d;

	logic               we, re;
	logic [IW-1:0]      waddr, raddr;
	logic [ENTRY_W-1:0] wdata, rdata;
	logic [TAG_W-1:0]   rd_tag;
	logic               rd_acc, rd_dirty, is_wr, out_free;

	// entry layout: tag, accessed, dirty
	sccp_ram #(.WIDTH(ENTRY_W), .DEPTH(NUM_SLOTS)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign rd_tag   = rdata[ENTRY_W-1:2];
	assign rd_acc   = rdata[1];
	assign rd_dirty = rdata[0];
	assign is_wr    = (cur_mode_q == MODE_WRITE);
	assign out_free = !ovalid_q || !out_stall;
	assign hand_nxt = (hand_q == IW'(NUM_SLOTS-1)) ? '0 : hand_q + 1'b1;

	assign status.clearing = (state_q == ST_CLEAR);

	always_comb begin
		state_d      = state_q;
		idx_d        = idx_q;
		used_d       = used_q;
		hand_d       = hand_q;
		cnt_d        = cnt_q;
		pend_d       = pend_q;
		pend_slot_d  = pend_slot_q;
		pend_tag_d   = pend_tag_q;
		cur_mode_d   = cur_mode_q;
		cur_sector_d = cur_sector_q;
		ovalid_d     = ovalid_q && out_stall;
		hit_d        = hit_q;
		slot_d       = slot_q;
		fill_d       = fill_q;
		wbv_d        = wbv_q;
		wbs_d        = wbs_q;
		last_d       = last_q;
		we           = 1'b0;
		waddr        = idx_q[IW-1:0];
		wdata        = '0;
		re           = 1'b0;
		raddr        = idx_q[IW-1:0];
		q_pop        = 1'b0;

		case (state_q)
			ST_CLEAR: begin
				we = 1'b1;
				if (idx_q == CW'(NUM_SLOTS-1)) begin
					idx_d   = '0;
					state_d = ST_IDLE;
				end else begin
					idx_d = idx_q + 1'b1;
				end
			end
			ST_IDLE: begin
				if (q_valid) begin
					q_pop        = 1'b1;
					cur_mode_d   = q_item.mode;
					cur_sector_d = q_item.sector;
					idx_d        = '0;
					cnt_d        = '0;
					pend_d       = 1'b0;
					state_d      = (q_item.mode == MODE_FLUSH) ? ST_FL_RD : ST_LK_RD;
				end
			end
			ST_LK_RD: begin
				if (idx_q == used_q) begin
					state_d = ST_MISS;
				end else begin
					re      = 1'b1;
					state_d = ST_LK_EV;
				end
			end
			ST_LK_EV: begin
				if (rd_tag == cur_sector_q) begin
					if (out_free) begin
						we       = 1'b1;
						wdata    = {rd_tag, 1'b1, rd_dirty | is_wr};
						ovalid_d = 1'b1;
						hit_d    = 1'b1;
						slot_d   = SLOT_W'(idx_q[IW-1:0]);
						fill_d   = 1'b0;
						wbv_d    = 1'b0;
						wbs_d    = '0;
						last_d   = 1'b1;
						state_d  = ST_IDLE;
					end
				end else begin
					idx_d   = idx_q + 1'b1;
					state_d = ST_LK_RD;
				end
			end
			ST_MISS: begin
				if (used_q != CW'(NUM_SLOTS)) begin
					if (out_free) begin
						we       = 1'b1;
						waddr    = used_q[IW-1:0];
						wdata    = {cur_sector_q, 1'b1, is_wr};
						used_d   = used_q + 1'b1;
						ovalid_d = 1'b1;
						hit_d    = 1'b0;
						slot_d   = SLOT_W'(used_q[IW-1:0]);
						fill_d   = 1'b1;
						wbv_d    = 1'b0;
						wbs_d    = '0;
						last_d   = 1'b1;
						state_d  = ST_IDLE;
					end
				end else begin
					re      = 1'b1;
					raddr   = hand_q;
					state_d = ST_CK_EV;
				end
			end
			ST_CK_EV: begin
				if (rd_acc) begin
					// second chance: drop the mark and look at the next slot
					we      = 1'b1;
					waddr   = hand_q;
					wdata   = {rd_tag, 1'b0, rd_dirty};
					hand_d  = hand_nxt;
					state_d = ST_MISS;
				end else if (out_free) begin
					we       = 1'b1;
					waddr    = hand_q;
					wdata    = {cur_sector_q, 1'b1, is_wr};
					hand_d   = hand_nxt;
					ovalid_d = 1'b1;
					hit_d    = 1'b0;
					slot_d   = SLOT_W'(hand_q);
					fill_d   = 1'b1;
					wbv_d    = rd_dirty;
					wbs_d    = rd_dirty ? rd_tag : '0;
					last_d   = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			ST_FL_RD: begin
				if (idx_q == used_q || cnt_q == CNT_W'(MAX_OUT)) begin
					state_d = ST_FL_END;
				end else begin
					re      = 1'b1;
					state_d = ST_FL_EV;
				end
			end
			ST_FL_EV: begin
				if (!rd_dirty) begin
					idx_d   = idx_q + 1'b1;
					state_d = ST_FL_RD;
				end else if (!pend_q || out_free) begin
					// the held result goes out once a later one is known
					if (pend_q) begin
						ovalid_d = 1'b1;
						hit_d    = 1'b0;
						slot_d   = SLOT_W'(pend_slot_q);
						fill_d   = 1'b0;
						wbv_d    = 1'b1;
						wbs_d    = pend_tag_q;
						last_d   = 1'b0;
					end
					we          = 1'b1;
					wdata       = {rd_tag, rd_acc, 1'b0};
					pend_d      = 1'b1;
					pend_slot_d = idx_q[IW-1:0];
					pend_tag_d  = rd_tag;
					cnt_d       = cnt_q + 1'b1;
					idx_d       = idx_q + 1'b1;
					state_d     = ST_FL_RD;
				end
			end
			ST_FL_END: begin
				if (!pend_q) begin
					state_d = ST_IDLE;
				end else if (out_free) begin
					ovalid_d = 1'b1;
					hit_d    = 1'b0;
					slot_d   = SLOT_W'(pend_slot_q);
					fill_d   = 1'b0;
					wbv_d    = 1'b1;
					wbs_d    = pend_tag_q;
					last_d   = 1'b1;
					pend_d   = 1'b0;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			idx_q    <= '0;
			used_q   <= '0;
			hand_q   <= '0;
			cnt_q    <= '0;
			pend_q   <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			idx_q    <= idx_d;
			used_q   <= used_d;
			hand_q   <= hand_d;
			cnt_q    <= cnt_d;
			pend_q   <= pend_d;
			ovalid_q <= ovalid_d;
		end
	end

	always_ff @(posedge clk) begin
		pend_slot_q  <= pend_slot_d;
		pend_tag_q   <= pend_tag_d;
		cur_mode_q   <= cur_mode_d;
		cur_sector_q <= cur_sector_d;
		hit_q        <= hit_d;
		slot_q       <= slot_d;
		fill_q       <= fill_d;
		wbv_q        <= wbv_d;
		wbs_q        <= wbs_d;
		last_q       <= last_d;
	end

	assign out_valid        = ovalid_q;
	assign hit              = hit_q;
	assign slot             = slot_q;
	assign fill_needed      = fill_q;
	assign writeback_valid  = wbv_q;
	assign writeback_sector = wbs_q;
	assign last             = last_q;

endmodule

@@ design/sector_cache_clock_policy_core.sv @@
// ----------------------------------------------------------------------------
// sector_cache_clock_policy_core
// tag and clock replacement controller for a fully associative sector cache
// ----------------------------------------------------------------------------
// lookup: a hit on slot k walks slots 0 to k, reading and comparing each in turn
// a miss walks all used slots, then steps the clock hand once every slot is in use
// flush: walks every used slot, with one slot ram port read per slot
// throughput: one item in the sequencer at a time, two more wait in the queue
// reset: async, then a clearing pass over all NUM_SLOTS slots with in_stall held high
`include "sector_cache_clock_policy_core_assert.svh"

module sector_cache_clock_policy_core import sccp_pkg::*; #(
	parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  mode,
	input  logic [31:0] sector,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic        hit,
	output logic [5:0]  slot,
	output logic        fill_needed,
	output logic        writeback_valid,
	output logic [31:0] writeback_sector,
	output logic        last
);

	// queue between front and sequencer
	logic         q_valid;
	logic         q_pop;
	sccp_item_t   q_item;
	sccp_status_t status;

	// front: takes a transfer, drops the unused mode, queues the rest
	sccp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.mode     (mode),
		.sector   (sector),
		.status   (status),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop)
	);

	// back: walks the slot ram for lookup, clock sweep and flush,
	// and owns the result register so it can run ahead of a stalled sink
	sccp_back #(.NUM_SLOTS(NUM_SLOTS)) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.q_valid          (q_valid),
		.q_item           (q_item),
		.q_pop            (q_pop),
		.status           (status),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.hit              (hit),
		.slot             (slot),
		.fill_needed      (fill_needed),
		.writeback_valid  (writeback_valid),
		.writeback_sector (writeback_sector),
		.last             (last)
	);

	// no input transfer while the slot ram is being cleared
	`SCCP_ASSERT_IMPLY(a_clear_stalls, status.clearing, in_stall, "transfer during clear")
	// a hit never asks for a fill or write-back
	`SCCP_ASSERT_IMPLY(a_hit_clean, out_valid && hit, !fill_needed && !writeback_valid, "hit with fill")
	// every result that is neither hit nor fill is a flush write-back
	`SCCP_ASSERT_IMPLY(a_flush_wb, out_valid && !hit && !fill_needed, writeback_valid, "empty result")
	// nothing comes out while clearing
	`SCCP_ASSERT_NEXT(a_clear_quiet, status.clearing && !out_valid, !out_valid, "result during clear")

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// drives random read, write and flush transfers into the sector cache core,
// predicts every result with a clock replacement model and checks each field
// ----------------------------------------------------------------------------

// expected-result store with its own copy of the cache state
class cache_scoreboard;
	localparam int SLOTS = 64;

	typedef struct {
		logic        hit;
		logic [5:0]  slot;
		logic        fill_needed;
		logic        writeback_valid;
		logic [31:0] writeback_sector;
		logic        last;
	} cache_result_t;

	logic [31:0]   tags [SLOTS];
	logic          accessed [SLOTS];
	logic          dirty [SLOTS];
	int unsigned   used;
	int unsigned   hand;
	cache_result_t pending_results [$];
	int            errors;

	function new();
		for (int i = 0; i < SLOTS; i++) begin
			tags[i] = '0;
			accessed[i] = 1'b0;
			dirty[i] = 1'b0;
		end
		used = 0;
		hand = 0;
		errors = 0;
	endfunction

	// work out the results of one accepted transfer
	function void note_access(logic [1:0] md, logic [31:0] sec);
		cache_result_t r;
		int unsigned s;
		int n;
		int lastk;
		bit found;
		n = 0;
		lastk = -1;
		found = 0;
		if (md == sccp_pkg::MODE_NONE)
			return;
		if (md == sccp_pkg::MODE_FLUSH) begin
			for (int i = 0; i < used && n < sccp_pkg::MAX_OUT; i++) begin
				if (dirty[i]) begin
					dirty[i] = 1'b0;
					r = '{1'b0, 6'(i), 1'b0, 1'b1, tags[i], 1'b0};
					pending_results.push_back(r);
					n++;
				end
			end
			if (n > 0)
				pending_results[pending_results.size()-1].last = 1'b1;
			return;
		end
		for (int i = 0; i < used && !found; i++) begin
			if (tags[i] == sec) begin
				found = 1;
				accessed[i] = 1'b1;
				if (md == sccp_pkg::MODE_WRITE)
					dirty[i] = 1'b1;
				r = '{1'b1, 6'(i), 1'b0, 1'b0, 32'd0, 1'b1};
				pending_results.push_back(r);
			end
		end
		if (found)
			return;
		r = '{1'b0, 6'd0, 1'b1, 1'b0, 32'd0, 1'b1};
		if (used < SLOTS) begin
			s = used;
			used++;
		end else begin
			while (accessed[hand]) begin
				accessed[hand] = 1'b0;
				hand = (hand + 1) % SLOTS;
			end
			s = hand;
			hand = (hand + 1) % SLOTS;
			if (dirty[s]) begin
				r.writeback_valid = 1'b1;
				r.writeback_sector = tags[s];
			end
		end
		r.slot = 6'(s);
		tags[s] = sec;
		accessed[s] = 1'b1;
		dirty[s] = (md == sccp_pkg::MODE_WRITE);
		pending_results.push_back(r);
	endfunction

	function void check_result(cache_result_t got);
		cache_result_t exp;
		if (pending_results.size() == 0) begin
			$display("%0t: unexpected result, expected none, actual %p", $realtime, got);
			errors++;
			return;
		end
		exp = pending_results.pop_front();
		if (got.hit !== exp.hit || got.slot !== exp.slot ||
				got.fill_needed !== exp.fill_needed ||
				got.writeback_valid !== exp.writeback_valid ||
				got.writeback_sector !== exp.writeback_sector ||
				got.last !== exp.last) begin
			$display("%0t: mismatch, expected %p, actual %p", $realtime, exp, got);
			errors++;
		end
	endfunction
endclass

module testbench;
	import sccp_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int RANDOM_ITEMS   = 500;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  mode;
	logic [31:0] sector;
	logic        out_valid;
	logic        out_stall;
	logic        hit;
	logic [5:0]  slot;
	logic        fill_needed;
	logic        writeback_valid;
	logic [31:0] writeback_sector;
	logic        last;

	cache_scoreboard sb;
	logic [31:0]     sector_pool [16];
	bit              hold_off;
	int              idle_cycles;

	sector_cache_clock_policy_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .mode(mode), .sector(sector),
		.out_valid(out_valid), .out_stall(out_stall), .hit(hit), .slot(slot),
		.fill_needed(fill_needed), .writeback_valid(writeback_valid),
		.writeback_sector(writeback_sector), .last(last)
	);

	always #1 clk = ~clk;

	// offer one transfer and hold it until accepted
	task automatic send_item(logic [1:0] md, logic [31:0] sec);
		in_valid <= 1'b1;
		mode <= md;
		sector <= sec;
		do @(posedge clk); while (in_stall);
		sb.note_access(md, sec);
	endtask

	task automatic send_gap();
		int g;
		g = $urandom_range(0, 3) == 0 ? $urandom_range(1, 6) : 0;
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	// mostly reuse a small set of sectors so hits, evictions and write-backs mix
	function automatic logic [31:0] pick_sector();
		int k;
		k = $urandom_range(0, 9);
		if (k < 7)
			return sector_pool[$urandom_range(0, 15)] + $urandom_range(0, 79);
		return $urandom();
	endfunction

	// monitor: sample the result channel at each rising edge
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result('{hit, slot, fill_needed, writeback_valid,
				writeback_sector, last});
	end

	// receiver stall pattern, with one long hold-off to fill the block up
	always @(posedge clk) begin
		if (!arst_n)
			out_stall <= 1'b0;
		else if (hold_off)
			out_stall <= 1'b1;
		else
			out_stall <= ($urandom_range(0, 7) < 2);
	end

	// watchdog counts cycles with no transfer on either channel
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// long receiver hold-off, counted here while the sender keeps offering
	initial begin
		hold_off = 1'b0;
		wait (arst_n);
		repeat (400) @(posedge clk);
		hold_off = 1'b1;
		repeat (300) @(posedge clk);
		hold_off = 1'b0;
	end

	initial begin
		sb = new();
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		mode = MODE_READ;
		sector = '0;
		idle_cycles = 0;
		for (int i = 0; i < 16; i++)
			sector_pool[i] = $urandom();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty flush, unused mode, extremes, hit, write hit, flush
		send_item(MODE_FLUSH, 32'd0);
		send_item(MODE_NONE, 32'hFFFF_FFFF);
		send_item(MODE_READ, 32'd0);
		send_item(MODE_WRITE, 32'hFFFF_FFFF);
		send_item(MODE_READ, 32'd0);
		send_item(MODE_WRITE, 32'd0);
		send_item(MODE_READ, 32'hFFFF_FFFF);
		send_item(MODE_READ, 32'hAAAA_5555);
		send_item(MODE_WRITE, 32'h5555_AAAA);
		send_item(MODE_FLUSH, 32'hFFFF_FFFF);
		send_item(MODE_FLUSH, 32'd0);
		// fill every slot dirty, then evict with write-backs and a full flush
		for (int i = 0; i < 66; i++)
			send_item(MODE_WRITE, 32'h1000_0000 + i);
		send_item(MODE_FLUSH, 32'd0);
		send_item(MODE_READ, 32'h1000_0003);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			int k;
			k = $urandom_range(0, 19);
			if (k == 0)
				send_item(MODE_FLUSH, $urandom());
			else if (k == 1)
				send_item(MODE_NONE, $urandom());
			else
				send_item(k < 11 ? MODE_READ : MODE_WRITE, pick_sector());
			send_gap();
		end
		in_valid <= 1'b0;

		while (sb.pending_results.size() != 0)
			@(posedge clk);
		repeat (600) @(posedge clk);
		if (sb.errors == 0 && sb.pending_results.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule

@@ files.f @@
+incdir+design
design/sccp_pkg.sv
design/sccp_ram.sv
design/sccp_front.sv
design/sccp_back.sv
design/sector_cache_clock_policy_core.sv
bench/testbench.sv
